/* rtl/core/vlcp_pkg.sv */
package vlcp_pkg;

    // Table geometry
    localparam int SYMBOL_COUNT    = 256;
    localparam int MAX_CODE_LENGTH = 24;
    localparam int SYM_AW          = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    // Field widths
    localparam int SYM_W   = 8;
    localparam int CODE_W  = 24;
    localparam int LEN_W   = 5;
    localparam int ACT_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int ACC_W   = 32;
    localparam int FILL_W  = 5;
    localparam int ENTRY_W = CODE_W + LEN_W;

    // Stream widths
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 8;

    // Range limits in field widths
    localparam logic [SYM_W:0]   SYM_LIMIT = (SYM_W + 1)'(SYMBOL_COUNT);
    localparam logic [LEN_W-1:0] MAX_LEN   = LEN_W'(MAX_CODE_LENGTH);

    // Item kinds carried on the input tuser
    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD   = 2'd0,
        ACT_ENCODE = 2'd1,
        ACT_FLUSH  = 2'd2
    } action_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT,
        ST_FLUSH
    } state_t;

    // One code table entry
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } entry_t;

endpackage

/* rtl/core/vlcp_ram.sv */
module vlcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                           wdata,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one entry, register the read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rd_data_reg <= mem[addr];
    end

    assign rdata = rd_data_reg;

endmodule

/* rtl/core/variable_length_code_packer_unit.sv */
// Load item: ready again on the next cycle, no output.
// Encode item: n output bytes (0..3), in order: the table read port, the merge shift,
// then one byte per cycle through the shifter while the output is not stalled.
// Flush item: its byte shows in the cycle after the output register frees up.
// Output bytes appear in the cycle after they are formed; output stalls add delay.
// Reset (rst_n low, asynchronous) clears the sequencer, accumulator, fill and output
// valid; the code table is not cleared and holds garbage until loaded.
module variable_length_code_packer_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [7:0] symbol, [31:8] code_bits, [36:32] code_length, [39:37] zero
    input  logic [vlcp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [1:0] action
    input  logic [vlcp_pkg::ACT_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [7:0] byte_out
    output logic [vlcp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tlast,
    // [0] end_of_stream
    output logic [0:0]                       m_axis_tuser
);

    import vlcp_pkg::*;

    state_t             state_reg, state_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]  m_byte_reg, m_byte_next;
    logic               m_last_reg, m_last_next;
    logic               m_eos_reg, m_eos_next;

    logic               in_fire;
    action_t            act;
    logic [SYM_W-1:0]   sym;
    logic [CODE_W-1:0]  code_in;
    logic [LEN_W-1:0]   len_in;
    logic [LEN_W-1:0]   len_clamp;
    logic [CODE_W-1:0]  code_mask;
    logic               sym_ok;
    logic               slot_free;
    logic               load_out;

    logic               ram_we;
    entry_t             ram_wdata;
    entry_t             ram_rdata;

    logic [FILL_W-1:0]  fill_sum;
    logic [BYTE_W-1:0]  flush_mask;

    // Decode the input item
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign act     = action_t'(s_axis_tuser);
    assign sym     = s_axis_tdata[7:0];
    assign code_in = s_axis_tdata[31:8];
    assign len_in  = s_axis_tdata[36:32];
    assign sym_ok  = {1'b0, sym} < SYM_LIMIT;

    // Clamp length and drop stray code bits on load
    assign len_clamp = (len_in > MAX_LEN) ? MAX_LEN : len_in;
    always_comb
    begin
        for (int i = 0; i < CODE_W; i++)
        begin
            code_mask[i] = (LEN_W'(i) < len_clamp);
        end
    end

    // Keep only the pending low bits for the padded flush byte
    always_comb
    begin
        for (int i = 0; i < BYTE_W; i++)
        begin
            flush_mask[i] = (3'(i) < fill_reg[2:0]);
        end
    end

    assign ram_we         = in_fire && (act == ACT_LOAD) && sym_ok;
    assign ram_wdata.len  = len_clamp;
    assign ram_wdata.code = code_in & code_mask;

    vlcp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (sym[SYM_AW-1:0]),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign fill_sum  = fill_reg + ram_rdata.len;
    assign slot_free = !m_valid_reg || m_axis_tready;

    // Sequencer: next state, accumulator update and output register load
    always_comb
    begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        fill_next    = fill_reg;
        load_out     = 1'b0;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        m_eos_next   = m_eos_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (act)
                        ACT_ENCODE:
                        begin
                            if (sym_ok)
                            begin
                                state_next = ST_READ;
                            end
                        end
                        ACT_FLUSH:
                        begin
                            state_next = ST_FLUSH;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // Merge the code above the pending bits
                acc_next   = acc_reg | (ACC_W'(ram_rdata.code) << fill_reg[2:0]);
                fill_next  = fill_sum;
                state_next = (fill_sum < FILL_W'(BYTE_W)) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                // Send one complete byte, low byte first
                if (slot_free)
                begin
                    load_out    = 1'b1;
                    m_byte_next = acc_reg[BYTE_W-1:0];
                    m_last_next = (fill_reg < FILL_W'(2 * BYTE_W));
                    m_eos_next  = 1'b0;
                    acc_next    = acc_reg >> BYTE_W;
                    fill_next   = fill_reg - FILL_W'(BYTE_W);
                    if (fill_reg < FILL_W'(2 * BYTE_W))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FLUSH:
            begin
                // Send the padded final byte and clear the accumulator
                if (slot_free)
                begin
                    load_out    = 1'b1;
                    m_byte_next = acc_reg[BYTE_W-1:0] & flush_mask;
                    m_last_next = 1'b1;
                    m_eos_next  = 1'b1;
                    acc_next    = '0;
                    fill_next   = '0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on load, drop when taken
    always_comb
    begin
        if (load_out)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            acc_reg     <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
        m_eos_reg  <= m_eos_next;
    end

    assign s_axis_tready   = (state_reg == ST_IDLE);
    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_byte_reg;
    assign m_axis_tlast    = m_last_reg;
    assign m_axis_tuser[0] = m_eos_reg;

endmodule

/* rtl/core/vlcp_checker.sv */
module vlcp_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [vlcp_pkg::ACT_W-1:0]       s_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [vlcp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                             m_axis_tlast,
    input  logic [0:0]                       m_axis_tuser
);

    import vlcp_pkg::*;

    logic in_fire;
    logic busy_kind;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign busy_kind = (s_axis_tuser == ACT_ENCODE) || (s_axis_tuser == ACT_FLUSH);

    // Stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("output item changed while stalled");

    // Padded flush byte always closes its run
    a_eos_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("end of stream byte without last");

    // Load and unused items leave the block ready on the next cycle
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !busy_kind |=> s_axis_tready)
        else $error("block busy after a load item");

    // Flush and in-range encode items hold off the next item
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && busy_kind |=> !s_axis_tready)
        else $error("block ready right after an encode or flush item");

endmodule

bind variable_length_code_packer_unit vlcp_checker u_vlcp_checker (.*);

/* test/tb_variable_length_code_packer_unit.sv */
`timescale 1ns / 1ps

module tb_variable_length_code_packer_unit;

    import vlcp_pkg::*;

    // Action code that the block ignores
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 144;
    localparam int SEED_LOADS   = 12;
    localparam int LONG_HOLD    = 300;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 16;

    // One packed output byte with its flags
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              eos;
    } packed_byte_t;

    // One row of the directed table; bytes are typed only where typed is set
    typedef struct packed {
        logic [ACT_W-1:0]       act;
        logic [SYM_W-1:0]       sym;
        logic [CODE_W-1:0]      code;
        logic [LEN_W-1:0]       len;
        logic                   typed;
        logic [1:0]             cnt;
        logic [2:0][BYTE_W-1:0] bytes;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    logic [ACT_W-1:0]       s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   m_axis_tlast;
    logic [0:0]             m_axis_tuser;

    // Typed expectation riding along with the item on offer
    logic                   cur_typed;
    logic [1:0]             cur_cnt;
    logic [2:0][BYTE_W-1:0] cur_bytes;

    // Packer state mirrored by the predictor
    logic [CODE_W-1:0]      code_mem [SYMBOL_COUNT];
    logic [LEN_W-1:0]       len_mem [SYMBOL_COUNT];
    logic [ACC_W-1:0]       acc_bits;
    logic [FILL_W-1:0]      acc_fill;

    packed_byte_t           packed_bytes_due [$];
    bit                     sym_loaded [SYMBOL_COUNT];
    logic [SYM_W-1:0]       loaded_syms [$];
    int                     errors;
    int                     idle_cycles;
    int                     hold_token;
    int                     burst_left;

    variable_length_code_packer_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Work out the bytes one item causes and advance the mirrored state
    task automatic pack_item(input logic [ACT_W-1:0] act, input logic [SYM_W-1:0] sym,
                             input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
                             output packed_byte_t res [3], output int n);
        logic [LEN_W-1:0] eff_len;
        logic [ACC_W-1:0] mask;
        n = 0;
        for (int i = 0; i < 3; i++)
            res[i] = '0;
        if (act == ACT_LOAD)
        begin
            eff_len = (len > MAX_LEN) ? MAX_LEN : len;
            mask = (eff_len == 0) ? '0 : ((ACC_W'(1) << eff_len) - 1);
            code_mem[sym] = code & mask[CODE_W-1:0];
            len_mem[sym] = eff_len;
        end
        else if (act == ACT_ENCODE)
        begin
            acc_fill = acc_fill & 5'd7;
            acc_bits = acc_bits | (ACC_W'(code_mem[sym]) << acc_fill);
            acc_fill = acc_fill + len_mem[sym];
            while (acc_fill >= 8 && n < 3)
            begin
                res[n].data = acc_bits[7:0];
                acc_bits = acc_bits >> 8;
                acc_fill = acc_fill - 5'd8;
                n++;
            end
            if (n > 0)
                res[n-1].last = 1'b1;
        end
        else if (act == ACT_FLUSH)
        begin
            mask = ((acc_fill & 5'd7) == 0) ? '0 : ((ACC_W'(1) << (acc_fill & 5'd7)) - 1);
            res[0].data = acc_bits[7:0] & mask[7:0];
            res[0].last = 1'b1;
            res[0].eos = 1'b1;
            acc_bits = '0;
            acc_fill = '0;
            n = 1;
        end
    endtask

    // Predict on an accepted input item; a typed row overrides the prediction
    task automatic take_input();
        packed_byte_t res [3];
        packed_byte_t typed_byte;
        int n;
        logic [ACT_W-1:0] act;
        act = s_axis_tuser;
        pack_item(act, s_axis_tdata[7:0], s_axis_tdata[31:8], s_axis_tdata[36:32], res, n);
        if (cur_typed)
        begin
            for (int i = 0; i < cur_cnt; i++)
            begin
                typed_byte.data = cur_bytes[i];
                typed_byte.last = (i == cur_cnt - 1);
                typed_byte.eos = (act == ACT_FLUSH);
                packed_bytes_due.push_back(typed_byte);
            end
        end
        else
        begin
            for (int i = 0; i < n; i++)
                packed_bytes_due.push_back(res[i]);
        end
    endtask

    // Compare an accepted output item with the oldest expectation
    task automatic check_output();
        packed_byte_t exp_byte;
        if (packed_bytes_due.size() == 0)
        begin
            $display("%0t: unexpected byte %02h last %0b eos %0b", $time,
                     m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
            errors++;
        end
        else
        begin
            exp_byte = packed_bytes_due.pop_front();
            if (m_axis_tdata !== exp_byte.data)
            begin
                $display("%0t: byte_out expected %02h actual %02h", $time,
                         exp_byte.data, m_axis_tdata);
                errors++;
            end
            if (m_axis_tlast !== exp_byte.last)
            begin
                $display("%0t: last_of_run expected %0b actual %0b", $time,
                         exp_byte.last, m_axis_tlast);
                errors++;
            end
            if (m_axis_tuser[0] !== exp_byte.eos)
            begin
                $display("%0t: end_of_stream expected %0b actual %0b", $time,
                         exp_byte.eos, m_axis_tuser[0]);
                errors++;
            end
        end
    endtask

    // Monitor both handshakes and count cycles with no traffic
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                take_input();
            if (m_axis_tvalid && m_axis_tready)
                check_output();
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("tb_variable_length_code_packer_unit failed");
        $finish;
    end

    // Receiver: changing stall patterns, plus a long hold-off on request
    initial
    begin : receiver
        int hold_seen;
        int rx_mode;
        int mode_left;
        hold_seen = 0;
        rx_mode = 0;
        mode_left = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(32, 96);
                end
                mode_left--;
                case (rx_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= $urandom_range(0, 1);
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Offer one item and hold it until accepted
    task automatic send_item(input logic [ACT_W-1:0] act, input logic [SYM_W-1:0] sym,
                             input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
                             input logic typed, input logic [1:0] cnt,
                             input logic [2:0][BYTE_W-1:0] bytes);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {3'b000, len, code, sym};
        cur_typed <= typed;
        cur_cnt <= cnt;
        cur_bytes <= bytes;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (act == ACT_LOAD && !sym_loaded[sym])
        begin
            sym_loaded[sym] = 1'b1;
            loaded_syms.push_back(sym);
        end
    endtask

    // Bursts of random length separated by random gaps
    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(1, 7);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
        end
    endtask

    function automatic logic [LEN_W-1:0] rand_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 7)
            return '0;
        else if (pick < 15)
            return LEN_W'($urandom_range(MAX_CODE_LENGTH + 1, 31));
        else
            return LEN_W'($urandom_range(1, MAX_CODE_LENGTH));
    endfunction

    function automatic dir_row_t mk_row(logic [ACT_W-1:0] act, logic [SYM_W-1:0] sym,
                                        logic [CODE_W-1:0] code, logic [LEN_W-1:0] len,
                                        int typed, int cnt,
                                        logic [BYTE_W-1:0] b0, logic [BYTE_W-1:0] b1,
                                        logic [BYTE_W-1:0] b2);
        dir_row_t row;
        row.act = act;
        row.sym = sym;
        row.code = code;
        row.len = len;
        row.typed = 1'(typed);
        row.cnt = 2'(cnt);
        row.bytes = {b2, b1, b0};
        return row;
    endfunction

    // Stimulus and final verdict
    initial
    begin : stimulus
        dir_row_t directed [$];
        dir_row_t row;
        logic [ACT_W-1:0] act;
        logic [SYM_W-1:0] sym;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0] len;
        int pick;
        int tail;

        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = ACT_LOAD;
        cur_typed = 1'b0;
        cur_cnt = '0;
        cur_bytes = '0;
        acc_bits = '0;
        acc_fill = '0;
        errors = 0;
        idle_cycles = 0;
        hold_token = 0;
        burst_left = 0;
        for (int i = 0; i < SYMBOL_COUNT; i++)
        begin
            code_mem[i] = '0;
            len_mem[i] = '0;
            sym_loaded[i] = 1'b0;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        //                act         sym    code        len    typ cnt  bytes
        directed.push_back(mk_row(ACT_FLUSH,  8'h00, 24'h000000, 5'd0,  1, 1, 8'h00, 8'h00, 8'h00));
        directed.push_back(mk_row(ACT_LOAD,   8'hFF, 24'hFFFFFF, 5'd24, 1, 0, 8'h00, 8'h00, 8'h00));
        directed.push_back(mk_row(ACT_ENCODE, 8'hFF, 24'h000000, 5'd0,  1, 3, 8'hFF, 8'hFF, 8'hFF));
        directed.push_back(mk_row(ACT_LOAD,   8'h00, 24'h000001, 5'd1,  1, 0, 8'h00, 8'h00, 8'h00));
        directed.push_back(mk_row(ACT_ENCODE, 8'h00, 24'h000000, 5'd0,  1, 0, 8'h00, 8'h00, 8'h00));
        directed.push_back(mk_row(ACT_FLUSH,  8'h00, 24'h000000, 5'd0,  1, 1, 8'h01, 8'h00, 8'h00));
        // length above the limit is clamped
        directed.push_back(mk_row(ACT_LOAD,   8'h01, 24'hFFFFFF, 5'd31, 0, 0, 8'h00, 8'h00, 8'h00));
        directed.push_back(mk_row(ACT_ENCODE, 8'h01, 24'h000000, 5'd0,  1, 3, 8'hFF, 8'hFF, 8'hFF));
        // empty code with stray bits
        directed.push_back(mk_row(ACT_LOAD,   8'h02, 24'hABCDEF, 5'd0,  0, 0, 8'h00, 8'h00, 8'h00));
        directed.push_back(mk_row(ACT_ENCODE, 8'h02, 24'h000000, 5'd0,  1, 0, 8'h00, 8'h00, 8'h00));
        // stray bits above a short length
        directed.push_back(mk_row(ACT_LOAD,   8'h03, 24'hFFFFFF, 5'd3,  0, 0, 8'h00, 8'h00, 8'h00));
        directed.push_back(mk_row(ACT_ENCODE, 8'h03, 24'h000000, 5'd0,  0, 0, 8'h00, 8'h00, 8'h00));
        directed.push_back(mk_row(ACT_ENCODE, 8'h00, 24'h000000, 5'd0,  0, 0, 8'h00, 8'h00, 8'h00));
        directed.push_back(mk_row(ACT_ENCODE, 8'h03, 24'h000000, 5'd0,  0, 0, 8'h00, 8'h00, 8'h00));
        // full code at a fill of seven
        directed.push_back(mk_row(ACT_ENCODE, 8'hFF, 24'h000000, 5'd0,  0, 0, 8'h00, 8'h00, 8'h00));
        directed.push_back(mk_row(ACT_FLUSH,  8'h00, 24'h000000, 5'd0,  0, 0, 8'h00, 8'h00, 8'h00));
        // unused action with every field set
        directed.push_back(mk_row(ACT_UNUSED, 8'hFF, 24'hFFFFFF, 5'd31, 1, 0, 8'h00, 8'h00, 8'h00));
        directed.push_back(mk_row(ACT_LOAD,   8'h80, 24'h000000, 5'd8,  0, 0, 8'h00, 8'h00, 8'h00));
        directed.push_back(mk_row(ACT_ENCODE, 8'h80, 24'h000000, 5'd0,  1, 1, 8'h00, 8'h00, 8'h00));
        directed.push_back(mk_row(ACT_LOAD,   8'h55, 24'h5A5A5A, 5'd20, 0, 0, 8'h00, 8'h00, 8'h00));
        directed.push_back(mk_row(ACT_ENCODE, 8'h55, 24'h000000, 5'd0,  0, 0, 8'h00, 8'h00, 8'h00));
        directed.push_back(mk_row(ACT_ENCODE, 8'hFF, 24'h000000, 5'd0,  0, 0, 8'h00, 8'h00, 8'h00));
        directed.push_back(mk_row(ACT_FLUSH,  8'h00, 24'h000000, 5'd0,  0, 0, 8'h00, 8'h00, 8'h00));
        directed.push_back(mk_row(ACT_FLUSH,  8'h00, 24'h000000, 5'd0,  1, 1, 8'h00, 8'h00, 8'h00));

        // Walk the directed table
        foreach (directed[i])
        begin
            row = directed[i];
            send_item(row.act, row.sym, row.code, row.len, row.typed, row.cnt, row.bytes);
            pace();
        end

        // Seed the table with random entries
        for (int i = 0; i < SEED_LOADS; i++)
        begin
            send_item(ACT_LOAD, SYM_W'($urandom_range(0, SYMBOL_COUNT - 1)),
                      CODE_W'($urandom), rand_len(), 1'b0, 2'd0, '0);
            pace();
        end

        // Random traffic, mostly encodes of loaded symbols
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 60)
            begin
                // hold off the receiver while the sender keeps offering
                hold_token <= hold_token + 1;
                burst_left = 40;
            end
            if (i == 120)
            begin
                // pause until every expected byte has come
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (packed_bytes_due.size() != 0)
                    @(posedge clk);
            end
            pick = $urandom_range(0, 99);
            sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
            code = CODE_W'($urandom);
            len = LEN_W'($urandom);
            if (pick < 70)
                act = ACT_ENCODE;
            else if (pick < 82)
            begin
                act = ACT_LOAD;
                len = rand_len();
                if ($urandom_range(0, 1) == 0)
                    sym = SYM_W'($urandom_range(0, SYMBOL_COUNT - 1));
            end
            else if (pick < 94)
                act = ACT_FLUSH;
            else
            begin
                act = ACT_UNUSED;
                sym = SYM_W'($urandom);
            end
            send_item(act, sym, code, len, 1'b0, 2'd0, '0);
            pace();
        end

        // Drain and let the block settle
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (packed_bytes_due.size() != 0)
            @(posedge clk);
        for (tail = 0; tail < TAIL_CYCLES; tail++)
            @(posedge clk);

        if (errors == 0 && packed_bytes_due.size() == 0)
            $display("tb_variable_length_code_packer_unit passed");
        else
            $display("tb_variable_length_code_packer_unit failed");
        $finish;
    end

endmodule
